FILE: rtl/core/grs_pkg.sv
// ----------------------------------------------------------------------------
// grs_pkg
// Types and constants shared by the grouped running sum block.
// ----------------------------------------------------------------------------
package grs_pkg;

   localparam int SUM_WIDTH      = 32;
   localparam int KEY_WIDTH      = 32;
   localparam int CSR_DATA_WIDTH = 32;
   localparam int CSR_ADDR_WIDTH = 3;

   // register index, taken from paddr[2]
   localparam logic REG_TRAILING_MODE = 1'b0;

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] sample_value;
      logic signed [KEY_WIDTH-1:0] group_key;
      logic                        start_of_set;
   } req_payload_type;

   typedef struct packed {
      logic signed [SUM_WIDTH-1:0] running_sum;
      logic                        table_overflow;
   } rsp_payload_type;

endpackage

FILE: rtl/core/grouped_running_sum_unit.sv
// ----------------------------------------------------------------------------
// grouped_running_sum_unit
// Segmented running sum per group id with a small associative table.
// ----------------------------------------------------------------------------
// One request is taken every clock cycle unless a result is held unread;
// it passes the input register, then the result register. The lookup and
// update of the group table between those registers sets this rate: the
// key match against every entry, the free entry pick and the 32-bit add
// all settle before the table is written, so the next request sees the
// updated table. No clearing pass follows reset; valid bits are cleared at
// once. The trailing_mode register (address 0) selects inclusive (0) or
// exclusive (1) sums; the user must write it only while idle, unenforced.
// ----------------------------------------------------------------------------
module grouped_running_sum_unit
   import grs_pkg::*;
#(
   parameter int MAX_GROUPS = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  req_payload_type           req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output rsp_payload_type           rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic            trailing_mode;
   logic            in_valid_ff;
   logic            in_valid_in;
   req_payload_type in_item_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   rsp_payload_type out_item_ff;
   rsp_payload_type table_result;
   logic            out_free;
   logic            advance;

   grs_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .trailing_mode (trailing_mode)
   );

   grs_group_table #(
      .MAX_GROUPS (MAX_GROUPS)
   ) u_table (
      .clock         (clock),
      .reset         (reset),
      .update_en     (advance),
      .item          (in_item_ff),
      .trailing_mode (trailing_mode),
      .result        (table_result)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= table_result;
      end
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

   a_ready_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && out_valid_ff && !rsp_ready))
      else $error("request stalled with room in the pipeline");

   a_overflow_zero_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.table_overflow |-> (rsp_payload.running_sum == '0))
      else $error("overflow result carries a nonzero sum");

   a_advance_fills_output: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("request moved on without a result");

endmodule

FILE: rtl/core/grs_csr.sv
// ----------------------------------------------------------------------------
// grs_csr
// APB register slave holding the trailing mode control bit.
// ----------------------------------------------------------------------------
module grs_csr
   import grs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output logic                      trailing_mode
);

   logic trailing_mode_ff;
   logic trailing_mode_in;
   logic wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      trailing_mode_in = trailing_mode_ff;
      if (wr_en && (paddr[2] == REG_TRAILING_MODE)) begin
         trailing_mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         trailing_mode_ff <= 1'b0;
      end else begin
         trailing_mode_ff <= trailing_mode_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == REG_TRAILING_MODE) begin
         prdata = {{(CSR_DATA_WIDTH-1){1'b0}}, trailing_mode_ff};
      end
   end

   assign trailing_mode = trailing_mode_ff;

endmodule

FILE: rtl/core/grs_group_table.sv
// ----------------------------------------------------------------------------
// grs_group_table
// Associative group table: parallel key match, free entry pick, sum update.
// ----------------------------------------------------------------------------
module grs_group_table
   import grs_pkg::*;
#(
   parameter int MAX_GROUPS = 16
)
(
   input  logic            clock,
   input  logic            reset,
   input  logic            update_en,
   input  req_payload_type item,
   input  logic            trailing_mode,
   output rsp_payload_type result
);

   logic [KEY_WIDTH-1:0] keys_ff [MAX_GROUPS];
   logic [SUM_WIDTH-1:0] sums_ff [MAX_GROUPS];
   logic [MAX_GROUPS-1:0] valid_ff;
   logic [MAX_GROUPS-1:0] valid_in;

   logic [MAX_GROUPS-1:0] eff_valid;
   logic [MAX_GROUPS-1:0] hit_vec;
   logic [MAX_GROUPS-1:0] free_onehot;
   logic [MAX_GROUPS-1:0] wr_onehot;
   logic                  hit_any;
   logic                  overflow;
   logic [SUM_WIDTH-1:0]  hit_sum;
   logic [SUM_WIDTH-1:0]  before_sum;
   logic [SUM_WIDTH-1:0]  after_sum;

   // start of set empties the table before the lookup
   assign eff_valid = item.start_of_set ? '0 : valid_ff;

   always_comb begin
      hit_sum = '0;
      for (int i = 0; i < MAX_GROUPS; i++) begin
         hit_vec[i] = eff_valid[i] && (keys_ff[i] == item.group_key);
         // keys are unique among valid entries, so at most one hit
         hit_sum    = hit_sum | ({SUM_WIDTH{hit_vec[i]}} & sums_ff[i]);
      end
   end

   // lowest clear bit of the valid vector
   assign free_onehot = ~eff_valid & (eff_valid + MAX_GROUPS'(1));
   assign hit_any     = |hit_vec;
   assign wr_onehot   = hit_any ? hit_vec : free_onehot;
   assign overflow    = !hit_any && (free_onehot == '0);
   assign before_sum  = hit_any ? hit_sum : '0;
   assign after_sum   = before_sum + item.sample_value;

   always_comb begin
      result.table_overflow = overflow;
      if (overflow) begin
         result.running_sum = '0;
      end else if (trailing_mode) begin
         result.running_sum = before_sum;
      end else begin
         result.running_sum = after_sum;
      end
   end

   assign valid_in = update_en ? (eff_valid | wr_onehot) : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_GROUPS; i++) begin
         if (update_en && wr_onehot[i]) begin
            keys_ff[i] <= item.group_key;
            sums_ff[i] <= after_sum;
         end
      end
   end

   a_hit_unique: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("group key matched more than one entry");

   a_start_single_entry: assert property (@(posedge clock) disable iff (reset)
      update_en && item.start_of_set |=> $onehot(valid_ff))
      else $error("table not left with one entry after start of set");

   a_overflow_full: assert property (@(posedge clock) disable iff (reset)
      overflow |-> (eff_valid == '1))
      else $error("overflow flagged while a free entry exists");

   a_overflow_keeps_table: assert property (@(posedge clock) disable iff (reset)
      update_en && overflow |=> (valid_ff == $past(valid_ff)))
      else $error("table changed on overflow");

endmodule

FILE: tb/sv/grs_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grs_result_checker
// Watches the request, result and register ports of the grouped running sum
// block, keeps its own group table to predict each result, and compares
// every result with the oldest prediction in order.
// ----------------------------------------------------------------------------
module grs_result_checker
   import grs_pkg::*;
#(
   parameter int MAX_GROUPS = 16
)
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  req_payload_type           req_payload,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  rsp_payload_type           rsp_payload,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   input  logic                      pready,
   output int                        fail_count,
   output int                        pending_results
);

   logic [KEY_WIDTH-1:0] slot_key  [MAX_GROUPS];
   logic [SUM_WIDTH-1:0] slot_sum  [MAX_GROUPS];
   logic                 slot_used [MAX_GROUPS];
   logic                 sum_mode;
   rsp_payload_type      expected_sums [$];

   initial begin
      fail_count      = 0;
      pending_results = 0;
   end

   // looks up or allocates the group entry and returns the sum the block owes
   function automatic rsp_payload_type accumulate_group_sum(req_payload_type r);
      int                   hit;
      int                   free_slot;
      logic [SUM_WIDTH-1:0] prior;
      logic [SUM_WIDTH-1:0] total;
      rsp_payload_type      res;
      hit       = -1;
      free_slot = -1;
      if (r.start_of_set) begin
         for (int i = 0; i < MAX_GROUPS; i++) begin
            slot_used[i] = 1'b0;
            slot_sum[i]  = '0;
         end
      end
      for (int i = 0; i < MAX_GROUPS; i++) begin
         if (slot_used[i]) begin
            if (hit < 0 && slot_key[i] == r.group_key) hit = i;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (hit < 0 && free_slot < 0) begin
         res.running_sum    = '0;
         res.table_overflow = 1'b1;
         return res;
      end
      if (hit < 0) begin
         hit            = free_slot;
         slot_used[hit] = 1'b1;
         slot_key[hit]  = r.group_key;
         slot_sum[hit]  = '0;
      end
      prior              = slot_sum[hit];
      total              = prior + r.sample_value;
      slot_sum[hit]      = total;
      res.running_sum    = sum_mode ? prior : total;
      res.table_overflow = 1'b0;
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_payload_type exp_rsp;
      if (reset) begin
         sum_mode = 1'b0;
         for (int i = 0; i < MAX_GROUPS; i++) begin
            slot_used[i] = 1'b0;
            slot_sum[i]  = '0;
         end
         expected_sums.delete();
      end else begin
         if (psel && penable && pwrite && pready && paddr[2] == REG_TRAILING_MODE)
            sum_mode = pwdata[0];
         if (req_valid && req_ready)
            expected_sums.push_back(accumulate_group_sum(req_payload));
         if (rsp_valid && rsp_ready) begin
            if (expected_sums.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected result: sum %0d overflow %0b",
                           rsp_payload.running_sum, rsp_payload.table_overflow);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = expected_sums.pop_front();
               if (exp_rsp.running_sum !== rsp_payload.running_sum ||
                   exp_rsp.table_overflow !== rsp_payload.table_overflow) begin
                  if (fail_count < 10)
                     $display("mismatch: expected sum %0d overflow %0b, got sum %0d overflow %0b",
                              exp_rsp.running_sum, exp_rsp.table_overflow,
                              rsp_payload.running_sum, rsp_payload.table_overflow);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
      pending_results <= expected_sums.size();
   end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random requests into the grouped running sum block
// through phases of sender idling and receiver stalls, switches between
// leading and trailing sums while idle, and reports the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import grs_pkg::*;

   localparam int MAX_GROUPS       = 16;
   localparam int CYCLE_LIMIT      = 400000;
   localparam int ITEMS_PER_PHASE  = 212;
   localparam logic [CSR_ADDR_WIDTH-1:0] MODE_ADDR  = {REG_TRAILING_MODE, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] SPARE_ADDR = {~REG_TRAILING_MODE, 2'b00};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   req_payload_type           req_payload = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   rsp_payload_type           rsp_payload;
   logic                      psel = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;
   int                        fail_count;
   int                        pending_results;

   int                        send_idle_pct  = 0;
   int                        recv_stall_pct = 0;
   int                        cycle_count    = 0;
   logic [KEY_WIDTH-1:0]      key_pool [20];
   int                        pool_size = 4;

   grouped_running_sum_unit #(.MAX_GROUPS(MAX_GROUPS)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   grs_result_checker #(.MAX_GROUPS(MAX_GROUPS)) u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .fail_count(fail_count), .pending_results(pending_results)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task automatic send_request(input logic [SUM_WIDTH-1:0] value,
                               input logic [KEY_WIDTH-1:0] key, input logic start);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{sample_value: value, group_key: key, start_of_set: start};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic set_register(input logic [CSR_ADDR_WIDTH-1:0] addr,
                               input logic [CSR_DATA_WIDTH-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // block idle: no request pending and every predicted result delivered
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_results != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'hffff_ffff;
         3: return 32'h0;
         4: return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   // mostly keys from a per-set pool so groups get hit; pool of 20 overflows
   task automatic send_random_request();
      logic                 start;
      logic [KEY_WIDTH-1:0] key;
      start = ($urandom_range(0, 39) == 0);
      if (start) begin
         case ($urandom_range(0, 2))
            0: pool_size = 3;
            1: pool_size = 16;
            default: pool_size = 20;
         endcase
         for (int i = 0; i < 20; i++)
            key_pool[i] = ($urandom_range(0, 3) == 0) ? pick_value() : $urandom();
      end
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, pool_size - 1)];
      else key = $urandom();
      send_request(pick_value(), key, start);
   endtask

   initial begin
      for (int i = 0; i < 20; i++) key_pool[i] = $urandom();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // upper bits are dropped; the spare address must not touch the mode
      set_register(MODE_ADDR, 32'hffff_fffe);
      set_register(SPARE_ADDR, 32'hffff_ffff);

      // leading sums: wrap at both extremes, extreme keys, then fill the table
      send_request(32'h7fff_ffff, 32'h0, 1'b1);
      send_request(32'h1, 32'h0, 1'b0);
      send_request(32'h8000_0000, 32'h8000_0000, 1'b0);
      send_request(32'hffff_ffff, 32'hffff_ffff, 1'b0);
      send_request(32'h8000_0000, 32'h8000_0000, 1'b0);
      for (int i = 1; i <= 13; i++) send_request(32'(i * 32'h1357_9bdf), 32'(i), 1'b0);
      send_request(32'h5, 32'h1234_5678, 1'b0);
      send_request(32'hffff_ffff, 32'h0, 1'b0);
      wait_for_drain();

      // trailing sums inside the same set, then overflow and a fresh set
      set_register(MODE_ADDR, 32'h0000_0001);
      send_request(32'h5, 32'h0, 1'b0);
      send_request(32'h9, 32'h0bad_f00d, 1'b0);
      send_request(32'h7, 32'h0bad_f00d, 1'b1);
      send_request(32'h3, 32'h0bad_f00d, 1'b0);
      wait_for_drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase / 2)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
            default: begin send_idle_pct = 16; recv_stall_pct = 16; end
         endcase
         set_register(MODE_ADDR, {31'($urandom()), 1'(phase % 2)});
         if (phase % 3 == 0) set_register(SPARE_ADDR, $urandom());
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_request();
         wait_for_drain();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
